>>> design/jss_pkg.sv
package jss_pkg;

  localparam int CHUNK_BITS = 32;
  localparam int CNT_W = $clog2(CHUNK_BITS + 1);
  localparam int SEQ_W = 6;
  localparam int SEQ_LEN_W = $clog2(SEQ_W + 1);

  localparam logic [1:0] OP_RESET = 2'd0;
  localparam logic [1:0] OP_IR = 2'd1;
  localparam logic [1:0] OP_DR = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [CHUNK_BITS-1:0] tdi_bits;
    logic [5:0] bit_count;
    logic final_chunk;
  } jss_in_t;

  typedef struct packed {
    logic tms;
    logic tdi;
    logic last;
  } jss_out_t;

  typedef enum logic [2:0] {
    SEQ_RESET,
    SEQ_HDR_IR,
    SEQ_HDR_DR_IDLE,
    SEQ_HDR_DR_PAUSE,
    SEQ_TAIL_EXIT,
    SEQ_TAIL_PAUSE
  } seq_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_DATA,
    ST_TAIL,
    ST_RST
  } state_t;

  typedef struct packed {
    logic load_item;
    logic open_scan;
    logic close_scan;
    logic load_seq;
    seq_sel_t seq_sel;
    logic emit_seq;
    logic emit_data;
    logic last;
  } jss_cmd_t;

  typedef struct packed {
    logic need_hdr;
    logic out_free;
    logic seq_last;
    logic bits_last;
    logic fin;
    logic op_ir;
    logic mode;
  } jss_sts_t;

  // TMS patterns are stored first step in bit 0.
  function automatic logic [SEQ_W-1:0] seq_pattern(seq_sel_t sel);
    logic [SEQ_W-1:0] p;
    unique case (sel)
      SEQ_RESET: p = 6'b011111;
      SEQ_HDR_IR: p = 6'b000110;
      SEQ_HDR_DR_IDLE: p = 6'b000010;
      SEQ_HDR_DR_PAUSE: p = 6'b000111;
      SEQ_TAIL_EXIT: p = 6'b000001;
      SEQ_TAIL_PAUSE: p = 6'b000000;
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [SEQ_LEN_W-1:0] seq_length(seq_sel_t sel);
    logic [SEQ_LEN_W-1:0] n;
    unique case (sel)
      SEQ_RESET: n = SEQ_LEN_W'(6);
      SEQ_HDR_IR: n = SEQ_LEN_W'(5);
      SEQ_HDR_DR_IDLE: n = SEQ_LEN_W'(4);
      SEQ_HDR_DR_PAUSE: n = SEQ_LEN_W'(5);
      SEQ_TAIL_EXIT: n = SEQ_LEN_W'(2);
      SEQ_TAIL_PAUSE: n = SEQ_LEN_W'(2);
      default: n = SEQ_LEN_W'(1);
    endcase
    return n;
  endfunction

endpackage

>>> design/jss_ctrl.sv
module jss_ctrl
  import jss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_ready,
  input  jss_sts_t   sts,
  output jss_cmd_t   cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.seq_sel = SEQ_RESET;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (in_op == OP_RESET) begin
            cmd.load_seq = 1'b1;
            cmd.seq_sel = SEQ_RESET;
            cmd.close_scan = 1'b1;
            state_next = ST_RST;
          end else if (in_op == OP_IR || in_op == OP_DR) begin
            if (sts.need_hdr) begin
              cmd.load_seq = 1'b1;
              cmd.open_scan = 1'b1;
              if (in_op == OP_IR) begin
                cmd.seq_sel = SEQ_HDR_IR;
              end else if (sts.mode) begin
                cmd.seq_sel = SEQ_HDR_DR_PAUSE;
              end else begin
                cmd.seq_sel = SEQ_HDR_DR_IDLE;
              end
              state_next = ST_HDR;
            end else begin
              state_next = ST_DATA;
            end
          end
        end
      end
      ST_HDR: begin
        if (sts.out_free) begin
          cmd.emit_seq = 1'b1;
          if (sts.seq_last) begin
            state_next = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (sts.out_free) begin
          cmd.emit_data = 1'b1;
          cmd.last = sts.bits_last && !sts.fin;
          if (sts.bits_last) begin
            if (sts.fin) begin
              cmd.load_seq = 1'b1;
              cmd.close_scan = 1'b1;
              cmd.seq_sel = (sts.op_ir && sts.mode) ? SEQ_TAIL_PAUSE : SEQ_TAIL_EXIT;
              state_next = ST_TAIL;
            end else begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      ST_TAIL, ST_RST: begin
        if (sts.out_free) begin
          cmd.emit_seq = 1'b1;
          cmd.last = sts.seq_last;
          if (sts.seq_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/jss_datapath.sv
module jss_datapath
  import jss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  jss_in_t  in_data,
  input  jss_cmd_t cmd,
  output jss_sts_t sts,
  output logic     out_valid,
  input  logic     out_ready,
  output jss_out_t out_data,
  input  logic     cfg_valid,
  input  logic     cfg_data
);

  logic mode;
  logic scan_open;
  logic [1:0] open_kind;
  logic [CHUNK_BITS-1:0] data_sr;
  logic [CNT_W-1:0] bits_left;
  logic fin;
  logic op_ir;
  logic [SEQ_W-1:0] seq_sr;
  logic [SEQ_LEN_W-1:0] seq_left;
  logic [CNT_W-1:0] count_clamped;

  always_comb begin
    if ({1'b0, in_data.bit_count} > 7'(CHUNK_BITS)) begin
      count_clamped = CNT_W'(CHUNK_BITS);
    end else if (in_data.bit_count == 6'd0) begin
      count_clamped = CNT_W'(1);
    end else begin
      count_clamped = CNT_W'(in_data.bit_count);
    end
  end

  always_comb begin
    sts.need_hdr = !scan_open || (open_kind != in_data.operation);
    sts.out_free = !out_valid || out_ready;
    sts.seq_last = (seq_left == SEQ_LEN_W'(1));
    sts.bits_last = (bits_left == CNT_W'(1));
    sts.fin = fin;
    sts.op_ir = op_ir;
    sts.mode = mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      scan_open <= 1'b0;
      open_kind <= OP_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode <= cfg_data;
      end
      if (cmd.close_scan) begin
        scan_open <= 1'b0;
        open_kind <= OP_RESET;
      end else if (cmd.open_scan) begin
        scan_open <= 1'b1;
        open_kind <= in_data.operation;
      end
      if (cmd.emit_seq || cmd.emit_data) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      data_sr <= in_data.tdi_bits;
      bits_left <= count_clamped;
      fin <= in_data.final_chunk;
      op_ir <= (in_data.operation == OP_IR);
    end else if (cmd.emit_data) begin
      data_sr <= data_sr >> 1;
      bits_left <= bits_left - CNT_W'(1);
    end
    if (cmd.load_seq) begin
      seq_sr <= seq_pattern(cmd.seq_sel);
      seq_left <= seq_length(cmd.seq_sel);
    end else if (cmd.emit_seq) begin
      seq_sr <= seq_sr >> 1;
      seq_left <= seq_left - SEQ_LEN_W'(1);
    end
    if (cmd.emit_seq) begin
      out_data.tms <= seq_sr[0];
      out_data.tdi <= 1'b0;
      out_data.last <= cmd.last;
    end else if (cmd.emit_data) begin
      out_data.tms <= fin && (bits_left == CNT_W'(1));
      out_data.tdi <= data_sr[0];
      out_data.last <= cmd.last;
    end
  end

endmodule

>>> design/jtag_scan_sequencer_top.sv
// Each accepted item is expanded into TCK steps, one step per clock cycle while the output is
// not stalled: a TAP reset gives six steps, and a scan chunk gives its header (four or five
// steps, only when a new scan opens), then bit_count data steps (clamped to 1..32), then a
// two-step tail on the final chunk. The datapath keeps separate step counters and shift
// registers for the data bits and the TMS sequences, and one item is handled at a time.
// Operation code 3 is accepted and produces no steps. The mode register may be written
// only while no item is in progress.
module jtag_scan_sequencer_top
  import jss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  jss_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output jss_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  jss_cmd_t cmd;
  jss_sts_t sts;

  assign cfg_ready = 1'b1;

  jss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jss_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data)
  );

endmodule
